// ===== sv/bep_pkg.sv =====
// shared types, character codes and helpers for the binary expression parser
package bep_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_BADOP      = 3'd3,
    ST_NEG        = 3'd4,
    ST_BADCHAR    = 3'd5,
    ST_FORMAT     = 3'd6,
    ST_DIVZERO    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_LDIG  = 3'd2,
    PH_LSPC  = 3'd3,
    PH_AFTOP = 3'd4,
    PH_RDIG  = 3'd5,
    PH_RSPC  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5
  } op_e;

  typedef enum logic {
    SEQ_PARSE = 1'b0,
    SEQ_CALC  = 1'b1
  } seq_e;

  typedef enum logic [2:0] {
    AS_IDLE = 3'd0,
    AS_MAGA = 3'd1,
    AS_MAGB = 3'd2,
    AS_LOOP = 3'd3,
    AS_SIGN = 3'd4
  } alu_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] value;
  } out_t;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

  function automatic op_e op_of(input logic [7:0] c);
    op_e o;
    case (c)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      CH_PCT:   o = OP_REM;
      default:  o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

// ===== sv/bep_alu.sv =====
// shared add/subtract unit sequenced for add, sub, shift-add multiply and restoring divide
module bep_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bep_pkg::alu_req_t req_i,
  output bep_pkg::alu_rsp_t rsp_o
);
  import bep_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  alu_state_e       st_q, st_d;
  op_e              op_q, op_d;
  logic [DataW-1:0] r_q, r_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] y_q, y_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [DataW-1:0] res_q, res_d;

  logic [DataW:0]   add_a, add_b, sum;
  logic             add_sub;
  logic             fits;
  logic [DataW-1:0] sel;

  // the one adder everything shares
  assign sum = add_a + (add_sub ? ~add_b : add_b) + (DataW+1)'(add_sub);

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    r_d     = r_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    fits    = 1'b0;
    sel     = (op_q == OP_DIV) ? x_q : r_q;
    unique case (st_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          x_d   = req_i.a;
          y_d   = req_i.b;
          r_d   = '0;
          cnt_d = '0;
          case (req_i.op) inside
            OP_ADD, OP_SUB: begin
              add_a   = {1'b0, req_i.a};
              add_b   = {1'b0, req_i.b};
              add_sub = (req_i.op == OP_SUB);
              res_d   = sum[DataW-1:0];
              done_d  = 1'b1;
            end
            OP_MUL: st_d = AS_LOOP;
            OP_DIV, OP_REM: begin
              neg_d = (req_i.op == OP_DIV) ? (req_i.a[DataW-1] ^ req_i.b[DataW-1])
                                           : req_i.a[DataW-1];
              st_d  = AS_MAGA;
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      AS_MAGA: begin
        add_b   = {1'b0, x_q};
        add_sub = 1'b1;
        if (x_q[DataW-1]) begin
          x_d = sum[DataW-1:0];
        end
        st_d = AS_MAGB;
      end
      AS_MAGB: begin
        add_b   = {1'b0, y_q};
        add_sub = 1'b1;
        if (y_q[DataW-1]) begin
          y_d = sum[DataW-1:0];
        end
        st_d = AS_LOOP;
      end
      AS_LOOP: begin
        if (op_q == OP_MUL) begin
          add_a = {1'b0, r_q};
          add_b = y_q[0] ? {1'b0, x_q} : '0;
          r_d   = sum[DataW-1:0];
          x_d   = {x_q[DataW-2:0], 1'b0};
          y_d   = {1'b0, y_q[DataW-1:1]};
        end else begin
          // remainder shifts in the next dividend bit, quotient bit shifts into x
          add_a   = {r_q, x_q[DataW-1]};
          add_b   = {1'b0, y_q};
          add_sub = 1'b1;
          fits    = !sum[DataW];
          r_d     = fits ? sum[DataW-1:0] : add_a[DataW-1:0];
          x_d     = {x_q[DataW-2:0], fits};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          if (op_q == OP_MUL) begin
            res_d  = sum[DataW-1:0];
            done_d = 1'b1;
            st_d   = AS_IDLE;
          end else begin
            st_d = AS_SIGN;
          end
        end
      end
      AS_SIGN: begin
        if (neg_q) begin
          add_b   = {1'b0, sel};
          add_sub = 1'b1;
        end else begin
          add_a = {1'b0, sel};
        end
        res_d  = sum[DataW-1:0];
        done_d = 1'b1;
        st_d   = AS_IDLE;
      end
      default: st_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AS_IDLE;
      op_q   <= OP_NONE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// ===== sv/binary_expression_parser_unit.sv =====
// top level: byte parser for "A op B" lines with an iterative arithmetic unit
// Each byte is parsed as it is accepted, and most bytes are taken back to back. A newline or end
// marker that completes a line starts the shared 33-bit add/subtract unit: add and subtract
// finish straight from its idle state, multiply takes 32 shift-add steps, and divide and
// remainder take two magnitude steps, 32 restoring steps and a sign fix.
// in_ready_o stays low while that unit works and while a finished result waits to be taken.
// Errors and divide by zero are flagged by the byte that causes them and registered to the output.
module binary_expression_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bep_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bep_pkg::out_t out_data_o
);
  import bep_pkg::*;

  seq_e             seq_q, seq_d;
  phase_e           phase_q, phase_d;
  op_e              op_q, op_d;
  logic [DataW-1:0] left_q, left_d;
  logic [DataW-1:0] right_q, right_d;
  logic             out_valid_q;
  out_t             out_q;

  logic             in_acc;
  logic             emit;
  status_e          emit_st;
  logic [DataW-1:0] emit_val;
  logic             calc;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  logic [7:0]       c;
  logic [DataW-1:0] dval;
  logic [DataW-1:0] left_x10, right_x10;
  op_e              opc;

  assign in_ready_o = (seq_q == SEQ_PARSE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign c         = in_data_i.data_byte;
  assign dval      = DataW'(c[3:0]);
  assign opc       = op_of(c);
  // x10 as x8 + x2, wrapping
  assign left_x10  = {left_q[DataW-4:0], 3'b000} + {left_q[DataW-2:0], 1'b0};
  assign right_x10 = {right_q[DataW-4:0], 3'b000} + {right_q[DataW-2:0], 1'b0};

  always_comb begin
    seq_d    = seq_q;
    phase_d  = phase_q;
    op_d     = op_q;
    left_d   = left_q;
    right_d  = right_q;
    emit     = 1'b0;
    emit_st  = ST_OK;
    emit_val = '0;
    calc     = 1'b0;
    alu_req  = '0;
    unique case (seq_q)
      SEQ_PARSE: begin
        if (in_acc) begin
          if (in_data_i.end_of_input) begin
            unique case (phase_q) inside
              PH_LEAD, PH_AFTOP: begin
                emit    = 1'b1;
                emit_st = ST_BADCHAR;
              end
              PH_LDIG, PH_LSPC: begin
                emit    = 1'b1;
                emit_st = ST_BADOP;
              end
              PH_RDIG, PH_RSPC: calc = 1'b1;
              default: begin
                phase_d = PH_IDLE;
                op_d    = OP_NONE;
              end
            endcase
          end else begin
            unique case (phase_q) inside
              PH_LDIG, PH_LSPC: begin
                if (phase_q == PH_LDIG && is_digit(c)) begin
                  left_d = left_x10 + dval;
                end else if (is_blank(c)) begin
                  phase_d = PH_LSPC;
                end else if (c == CH_NL) begin
                  emit    = 1'b1;
                  emit_st = ST_INCOMPLETE;
                end else if (opc == OP_NONE) begin
                  emit    = 1'b1;
                  emit_st = ST_BADOP;
                end else begin
                  op_d    = opc;
                  phase_d = PH_AFTOP;
                end
              end
              PH_AFTOP: begin
                if (is_blank(c)) begin
                  phase_d = PH_AFTOP;
                end else if (c == CH_NL) begin
                  emit    = 1'b1;
                  emit_st = ST_INCOMPLETE;
                end else if (is_digit(c)) begin
                  right_d = dval;
                  phase_d = PH_RDIG;
                end else if (c == CH_MINUS) begin
                  emit    = 1'b1;
                  emit_st = ST_NEG;
                end else begin
                  emit    = 1'b1;
                  emit_st = ST_BADCHAR;
                end
              end
              PH_RDIG, PH_RSPC: begin
                if (phase_q == PH_RDIG && is_digit(c)) begin
                  right_d = right_x10 + dval;
                end else if (is_blank(c)) begin
                  phase_d = PH_RSPC;
                end else if (c == CH_NL) begin
                  calc = 1'b1;
                end else begin
                  emit    = 1'b1;
                  emit_st = ST_FORMAT;
                end
              end
              default: begin
                // idle or leading blanks
                if (is_blank(c)) begin
                  phase_d = PH_LEAD;
                end else if (c == CH_NL) begin
                  emit    = 1'b1;
                  emit_st = ST_EMPTY;
                end else if (is_digit(c)) begin
                  left_d  = dval;
                  phase_d = PH_LDIG;
                end else if (c == CH_MINUS) begin
                  emit    = 1'b1;
                  emit_st = ST_NEG;
                end else begin
                  emit    = 1'b1;
                  emit_st = ST_BADCHAR;
                end
              end
            endcase
          end
          if (calc) begin
            if ((op_q == OP_DIV || op_q == OP_REM) && right_q == '0) begin
              emit    = 1'b1;
              emit_st = ST_DIVZERO;
            end else if (op_q == OP_NONE) begin
              emit    = 1'b1;
              emit_st = ST_OK;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = op_q;
              alu_req.a     = left_q;
              alu_req.b     = right_q;
              seq_d         = SEQ_CALC;
              phase_d       = PH_IDLE;
              op_d          = OP_NONE;
            end
          end
        end
      end
      SEQ_CALC: begin
        if (alu_rsp.done) begin
          emit     = 1'b1;
          emit_st  = ST_OK;
          emit_val = alu_rsp.result;
          seq_d    = SEQ_PARSE;
        end
      end
      default: seq_d = SEQ_PARSE;
    endcase
    if (emit) begin
      phase_d = PH_IDLE;
      op_d    = OP_NONE;
    end
  end

  bep_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_PARSE;
      phase_q     <= PH_IDLE;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    if (emit) begin
      out_q.status <= emit_st;
      out_q.value  <= emit_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_calc_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_CALC) |-> !in_ready_o)
    else $error("input taken while arithmetic unit busy");

  a_done_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (seq_q == SEQ_CALC))
    else $error("arithmetic result with no line pending");

  a_start_enters_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |=> (seq_q == SEQ_CALC) && (phase_q == PH_IDLE))
    else $error("start did not hand the line to the arithmetic unit");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.value == '0))
    else $error("error item carries a nonzero value");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("pending item overwritten");

endmodule

// ===== test/tb_binary_expression_parser_unit.sv =====
// testbench for binary_expression_parser_unit: line stimulus, own line predictor, result check
module tb_binary_expression_parser_unit;
  import bep_pkg::*;

  // predicts the result of every accepted item and checks results against it
  class expr_scoreboard;
    phase_e      phase;
    logic [31:0] lhs;
    logic [31:0] rhs;
    op_e         opr;
    out_t        expected_q[$];
    int unsigned errors;

    function new();
      clear_line();
      errors = 0;
    endfunction

    function void clear_line();
      phase = PH_IDLE;
      lhs   = '0;
      rhs   = '0;
      opr   = OP_NONE;
    endfunction

    function void push_result(status_e st, logic [31:0] v);
      out_t e;
      e.status = st;
      e.value  = v;
      expected_q.push_back(e);
      clear_line();
    endfunction

    function op_e opcode_for(logic [7:0] c);
      case (c)
        CH_PLUS:  return OP_ADD;
        CH_MINUS: return OP_SUB;
        CH_STAR:  return OP_MUL;
        CH_SLASH: return OP_DIV;
        CH_PCT:   return OP_REM;
        default:  return OP_NONE;
      endcase
    endfunction

    function void calc_result();
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] r;
      ma = lhs[31] ? 32'd0 - lhs : lhs;
      mb = rhs[31] ? 32'd0 - rhs : rhs;
      case (opr)
        OP_ADD: r = lhs + rhs;
        OP_SUB: r = lhs - rhs;
        OP_MUL: r = lhs * rhs;
        OP_DIV, OP_REM: begin
          if (rhs == 32'd0) begin
            push_result(ST_DIVZERO, 32'd0);
            return;
          end
          if (opr == OP_DIV) begin
            r = ma / mb;
            if (lhs[31] != rhs[31]) r = 32'd0 - r;
          end else begin
            // remainder follows the sign of the dividend
            r = ma % mb;
            if (lhs[31]) r = 32'd0 - r;
          end
        end
        default: r = 32'd0;
      endcase
      push_result(ST_OK, r);
    endfunction

    function void note_item(in_t it);
      logic [7:0]  c;
      logic        dig;
      logic        blank;
      logic [31:0] dv;
      op_e         o;
      c     = it.data_byte;
      dig   = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_SPACE) || (c == CH_TAB);
      dv    = {24'd0, c} - {24'd0, CH_ZERO};
      if (it.end_of_input) begin
        case (phase)
          PH_LEAD, PH_AFTOP: push_result(ST_BADCHAR, 32'd0);
          PH_LDIG, PH_LSPC:  push_result(ST_BADOP, 32'd0);
          PH_RDIG, PH_RSPC:  calc_result();
          default:           clear_line();
        endcase
        return;
      end
      case (phase)
        PH_LDIG, PH_LSPC: begin
          if (phase == PH_LDIG && dig) begin
            lhs = lhs * 32'd10 + dv;
          end else if (blank) begin
            phase = PH_LSPC;
          end else if (c == CH_NL) begin
            push_result(ST_INCOMPLETE, 32'd0);
          end else begin
            o = opcode_for(c);
            if (o == OP_NONE) begin
              push_result(ST_BADOP, 32'd0);
            end else begin
              opr   = o;
              phase = PH_AFTOP;
            end
          end
        end
        PH_AFTOP: begin
          if (blank) begin
          end else if (c == CH_NL) begin
            push_result(ST_INCOMPLETE, 32'd0);
          end else if (dig) begin
            rhs   = dv;
            phase = PH_RDIG;
          end else if (c == CH_MINUS) begin
            push_result(ST_NEG, 32'd0);
          end else begin
            push_result(ST_BADCHAR, 32'd0);
          end
        end
        PH_RDIG, PH_RSPC: begin
          if (phase == PH_RDIG && dig) begin
            rhs = rhs * 32'd10 + dv;
          end else if (blank) begin
            phase = PH_RSPC;
          end else if (c == CH_NL) begin
            calc_result();
          end else begin
            push_result(ST_FORMAT, 32'd0);
          end
        end
        default: begin
          if (phase != PH_LEAD) clear_line();
          if (blank) begin
            phase = PH_LEAD;
          end else if (c == CH_NL) begin
            push_result(ST_EMPTY, 32'd0);
          end else if (dig) begin
            lhs   = dv;
            phase = PH_LDIG;
          end else if (c == CH_MINUS) begin
            push_result(ST_NEG, 32'd0);
          end else begin
            push_result(ST_BADCHAR, 32'd0);
          end
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d value %0d", got.status, got.value);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, got.value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready_o;
  in_t  in_data   = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;

  expr_scoreboard sb;
  in_t            line_q[$];
  int unsigned    items_sent = 0;
  int unsigned    batch      = 0;
  bit             calm       = 1'b0;
  bit             hold_req   = 1'b0;
  logic [7:0]     op_chars[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};

  binary_expression_parser_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // input first, then output: each accepted byte is noted before results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_item(in_data);
      if (out_valid_o && out_ready) sb.check_result(out_data_o);
    end
  end

  // receiver: random ready pattern, plus one long hold-off on request
  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b0;
        case ($urandom_range(0, 24))
          0:             repeat ($urandom_range(30, 250)) @(negedge clk_i);
          1, 2, 3, 4:    repeat ($urandom_range(4, 20)) @(negedge clk_i);
          default:       repeat ($urandom_range(1, 3)) @(negedge clk_i);
        endcase
      end
    end
  end

  task automatic send_item(input in_t it);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i]);
    line_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    in_t it;
    it.data_byte    = b;
    it.end_of_input = 1'b0;
    line_q.push_back(it);
  endtask

  task automatic add_end();
    in_t it;
    it.data_byte    = 8'($urandom);
    it.end_of_input = 1'b1;
    line_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_blanks();
    int unsigned n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_decimal(input logic [63:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 15) == 0) digs.push_front(CH_ZERO);
    foreach (digs[i]) add_byte(digs[i]);
  endtask

  task automatic add_number(input bit right_side);
    logic [63:0] v;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      v = $urandom_range(0, 99);
    end else if (k < 62) begin
      v = {32'd0, $urandom};
    end else if (k < 88) begin
      case ($urandom_range(0, 4))
        0:       v = 64'd0;
        1:       v = 64'd1;
        2:       v = 64'd2147483647;
        3:       v = 64'd2147483648;
        default: v = 64'd4294967295;
      endcase
    end else begin
      // long digit strings wrap the accumulator
      repeat ($urandom_range(10, 14)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      return;
    end
    if (right_side && $urandom_range(0, 9) == 0) v = 64'd0;
    add_decimal(v);
  endtask

  task automatic build_line();
    bit special;
    special = ($urandom_range(0, 29) == 0);
    add_blanks();
    if (special) add_decimal(64'd2147483648);
    else add_number(1'b0);
    add_blanks();
    if (special) add_byte($urandom_range(0, 1) ? CH_SLASH : CH_PCT);
    else add_byte(op_chars[$urandom_range(0, 4)]);
    add_blanks();
    if (special) add_decimal(64'd4294967295);
    else add_number(1'b1);
    add_blanks();
    if ($urandom_range(0, 99) < 85) add_byte(CH_NL);
    else add_end();
  endtask

  task automatic build_broken_line();
    int unsigned pos;
    logic [7:0]  b;
    in_t         it;
    build_line();
    if ($urandom_range(0, 3) == 0) line_q.delete(line_q.size() - 1);
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 5))
      0:       b = CH_MINUS;
      1:       b = CH_NL;
      2:       b = op_chars[$urandom_range(0, 4)];
      3:       b = 8'(CH_ZERO + $urandom_range(0, 9));
      4:       b = 8'($urandom_range(0, 255));
      default: b = CH_SPACE;
    endcase
    it.data_byte    = b;
    it.end_of_input = 1'b0;
    if ($urandom_range(0, 1)) line_q[pos] = it;
    else line_q.insert(pos, it);
  endtask

  initial begin
    int unsigned k;
    in_t         it;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: end marker while idle, then lines that end in each error status and in one result
    it.data_byte    = 8'hFF;
    it.end_of_input = 1'b1;
    line_q.push_back(it);
    add_text("\n");
    add_text(" ");
    add_end();
    add_text("7");
    add_end();
    add_text("3+");
    add_end();
    add_text("9\t\n");
    add_text("-");
    add_byte(8'h00);
    add_text("1+2 3");
    add_text("8/0\n");
    add_text("2*3");
    add_end();
    send_line();

    while (items_sent < 1725) begin
      calm = ($urandom_range(0, 5) == 0);
      if (batch == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        calm     = 1'b1;
      end
      if (batch == 5 || batch % 40 == 39) wait_drained();
      repeat (8) begin
        k = $urandom_range(0, 99);
        if (k < 70) begin
          build_line();
        end else if (k < 90) begin
          build_broken_line();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) add_end();
            else if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
            else add_byte(op_chars[$urandom_range(0, 4)]);
          end
        end
        send_line();
      end
      batch++;
    end

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[binary_expression_parser_unit] OK");
    end else begin
      $display("[binary_expression_parser_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[binary_expression_parser_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bep_pkg.sv
sv/bep_alu.sv
sv/binary_expression_parser_unit.sv
test/tb_binary_expression_parser_unit.sv
